@@ hw/rtl/igdq_pkg.sv @@
// Shared constants, widths and controller/datapath command and status types for the INT4 dequant dot product.
package igdq_pkg;

  localparam int unsigned Lanes     = 8;
  localparam int unsigned NibW      = 4;
  localparam int unsigned ActW      = 16;
  localparam int unsigned ScaleW    = 16;
  localparam int unsigned ZeroW     = 8;
  localparam int unsigned WordW     = Lanes * NibW;
  localparam int unsigned DotW      = 24;   // |dot| < 2^22
  localparam int unsigned SumW      = 20;   // |sum| <= 2^18
  localparam int unsigned ZsW       = 29;   // zero * sum
  localparam int unsigned DiffW     = 30;   // dot*16 - zero*sum
  localparam int unsigned TermW     = 47;   // scale * diff
  localparam int unsigned AccW      = 64;

  localparam logic [NibW-1:0] NibMask = 4'hF;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // Controller to datapath: one strobe per datapath step.
  typedef struct packed {
    logic load;   // capture the accepted input beat
    logic dot;    // form lane dot product and activation sum
    logic diff;   // form dot*16 - zero*sum
    logic mul;    // form scale * diff
    logic acc;    // saturating add; emit and clear on row end
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;   // captured row_end of the item in flight
  } status_t;

endpackage

@@ hw/rtl/igdq_if.sv @@
// Valid/ready channel interfaces for the input item and the result beat.
interface igdq_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] packed_weights;
  logic        [15:0] group_scale;
  logic        [7:0]  group_zero;
  logic signed [15:0] act_0;
  logic signed [15:0] act_1;
  logic signed [15:0] act_2;
  logic signed [15:0] act_3;
  logic signed [15:0] act_4;
  logic signed [15:0] act_5;
  logic signed [15:0] act_6;
  logic signed [15:0] act_7;
  logic               row_end;

  modport source (
    output valid, packed_weights, group_scale, group_zero,
    output act_0, act_1, act_2, act_3, act_4, act_5, act_6, act_7, row_end,
    input  ready
  );
  modport sink (
    input  valid, packed_weights, group_scale, group_zero,
    input  act_0, act_1, act_2, act_3, act_4, act_5, act_6, act_7, row_end,
    output ready
  );
endinterface

interface igdq_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] out_value;

  modport source (output valid, out_value, input ready);
  modport sink   (input valid, out_value, output ready);
endinterface

@@ hw/rtl/int4_group_dequant_dot_product.sv @@
// Top level of the INT4 group dequantize-and-accumulate dot product.
//
//   channel   modport   beat contents
//   -------   -------   --------------------------------------------------------
//   weights   sink      packed_weights, group_scale, group_zero, act_0..act_7, row_end
//   result    source    out_value (signed Q31.32, saturated), one beat per row end
//
// Each item passes through five steps of the shared datapath: the accept edge captures it,
// then the lane dot product and activation sum, zero-point correction (8x20 multiply),
// scaling (17x30 multiply) and the saturating 64-bit add follow in that order; the
// accumulator and result valid update at the add step, which a stalled result can hold.
// The weights channel is ready only between items, so a new item is not accepted
// until the accumulate step of the one before it has completed.
// rst is synchronous and active high; it clears the accumulator and the result
// valid flag. The result sits in an output register, so the next items are
// accepted while it waits; a stalled result only holds the accumulate step of
// the next row-end item until the beat is taken.
module int4_group_dequant_dot_product import igdq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  igdq_in_if.sink    weights,
  igdq_out_if.source result
);

  cmd_t                  cmd;
  status_t               status;
  logic signed [ActW-1:0] act_lanes [Lanes];

  // Gather the per-lane activation fields into one lane array.
  assign act_lanes[0] = weights.act_0;
  assign act_lanes[1] = weights.act_1;
  assign act_lanes[2] = weights.act_2;
  assign act_lanes[3] = weights.act_3;
  assign act_lanes[4] = weights.act_4;
  assign act_lanes[5] = weights.act_5;
  assign act_lanes[6] = weights.act_6;
  assign act_lanes[7] = weights.act_7;

  igdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (weights.valid),
    .in_ready  (weights.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  igdq_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .packed_weights (weights.packed_weights),
    .group_scale    (weights.group_scale),
    .group_zero     (weights.group_zero),
    .act            (act_lanes),
    .row_end        (weights.row_end),
    .out_value      (result.out_value)
  );

endmodule

@@ hw/rtl/igdq_datapath.sv @@
// Datapath: input capture, lane products, zero-point correction, scaling and saturating accumulator.
module igdq_datapath import igdq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic        [WordW-1:0]   packed_weights,
  input  logic        [ScaleW-1:0]  group_scale,
  input  logic        [ZeroW-1:0]   group_zero,
  input  logic signed [ActW-1:0]    act [Lanes],
  input  logic                      row_end,
  output logic signed [AccW-1:0]    out_value
);

  logic        [WordW-1:0]  word_q;
  logic        [ScaleW-1:0] scale_q;
  logic        [ZeroW-1:0]  zero_q;
  logic signed [ActW-1:0]   act_q [Lanes];
  logic                     last_q;

  logic signed [DotW-1:0]   dot_q;
  logic signed [SumW-1:0]   sum_q;
  logic signed [DiffW-1:0]  diff_q;
  logic signed [TermW-1:0]  term_q;
  logic signed [AccW-1:0]   accumulator;

  logic signed [DotW-1:0]   dot_next;
  logic signed [SumW-1:0]   sum_next;
  logic signed [ZsW-1:0]    zs;
  logic signed [DiffW-1:0]  diff_next;
  logic signed [TermW-1:0]  term_next;
  logic signed [AccW:0]     acc_wide;
  logic signed [AccW-1:0]   acc_sat;

  assign status.last = last_q;

  // Lane products are narrow (4 x 16); the eight lanes are independent.
  always_comb begin
    logic signed [ActW+NibW:0] prod;
    dot_next = '0;
    sum_next = '0;
    for (int i = 0; i < Lanes; i++) begin
      prod     = $signed({1'b0, word_q[NibW*i +: NibW] & NibMask}) * act_q[i];
      dot_next = dot_next + DotW'(prod);
      sum_next = sum_next + SumW'(act_q[i]);
    end
  end

  assign zs        = $signed({1'b0, zero_q}) * sum_q;
  assign diff_next = DiffW'($signed({dot_q, 4'b0000})) - DiffW'(zs);
  assign term_next = $signed({1'b0, scale_q}) * diff_q;

  // Saturate when the carry into the extra bit disagrees with the sign bit.
  assign acc_wide = {accumulator[AccW-1], accumulator} + (AccW+1)'(term_q);
  always_comb begin
    if (acc_wide[AccW] != acc_wide[AccW-1]) begin
      acc_sat = acc_wide[AccW] ? AccMin : AccMax;
    end else begin
      acc_sat = acc_wide[AccW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_q  <= packed_weights;
      scale_q <= group_scale;
      zero_q  <= group_zero;
      act_q   <= act;
      last_q  <= row_end;
    end
    if (cmd.dot) begin
      dot_q <= dot_next;
      sum_q <= sum_next;
    end
    if (cmd.diff) begin
      diff_q <= diff_next;
    end
    if (cmd.mul) begin
      term_q <= term_next;
    end
    if (cmd.acc && last_q) begin
      out_value <= acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
    end else if (cmd.acc) begin
      accumulator <= last_q ? '0 : acc_sat;
    end
  end

endmodule

@@ hw/rtl/igdq_ctrl.sv @@
// Controller: sequences one item through the datapath steps and owns the result valid flag.
module igdq_ctrl import igdq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DOT  = 5'b00010,
    ST_DIFF = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_ACC  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   acc_stall;

  assign in_ready  = (state == ST_IDLE);
  // Hold the accumulate step of a row-end item while an earlier result still waits.
  assign acc_stall = status.last && out_valid && !out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DOT;
        end
      end
      ST_DOT: begin
        cmd.dot    = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (!acc_stall) begin
          cmd.acc    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.acc && status.last) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.acc && status.last && out_valid && !out_ready))
    else $error("pending result overwritten");

  a_row_end_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.acc && status.last |=> out_valid)
    else $error("row end did not raise result valid");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_DOT && !in_ready)
    else $error("accepted beat did not start the sequence");

  a_acc_leaves: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |=> in_ready)
    else $error("controller did not return to idle after accumulate");

endmodule
